>>> src/tsgc_pkg.sv
// ----------------------------------------------------------------------------
// tsgc_pkg
// Types, codes and defaults shared by the touch slide gesture classifier.
// ----------------------------------------------------------------------------
package tsgc_pkg;

  // Default configuration of the top level
  localparam int unsigned CELL_COUNT_DEF = 32;
  localparam int unsigned SLOTS_DEF      = 10;

  // Widths fixed by the interface
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CELL_W  = 5;

  // Operand width of the shared subtractor
  localparam int unsigned OPW = COORD_W + 1;

  // Threshold after reset
  localparam logic [COORD_W-1:0] THR_RESET = 16'd600;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTE_X = 3'd0,
    CFG_ROUTE_Y = 3'd1,
    CFG_LEFT_X  = 3'd2,
    CFG_LEFT_Y  = 3'd3,
    CFG_RIGHT_X = 3'd4,
    CFG_RIGHT_Y = 3'd5,
    CFG_THRESH  = 3'd6,
    CFG_UNUSED  = 3'd7
  } cfg_idx_e;

  // Number of bounds registers
  localparam int unsigned BND_N = 6;

  // Zone of a press
  typedef enum logic [1:0] {
    ZONE_NONE    = 2'd0,
    ZONE_ROUTING = 2'd1,
    ZONE_LEFT    = 2'd2,
    ZONE_RIGHT   = 2'd3
  } zone_e;

  // Result commands
  typedef enum logic [CMD_W-1:0] {
    CMD_ROUTE     = 3'd0,
    CMD_WIN_LEFT  = 3'd1,
    CMD_WIN_RIGHT = 3'd2,
    CMD_LINE_UP   = 3'd3,
    CMD_LINE_DOWN = 3'd4
  } cmd_e;

  // Result and flags of the shared subtractor
  typedef struct packed {
    logic [OPW-1:0] diff;
    logic           borrow;
    logic           zero;
  } alu_res_t;

  // Map a rectangle number in priority order to its zone
  function automatic zone_e zone_of_rect(input logic [1:0] rect);
    zone_e z;
    case (rect)
      2'd0:    z = ZONE_ROUTING;
      2'd1:    z = ZONE_LEFT;
      2'd2:    z = ZONE_RIGHT;
      default: z = ZONE_NONE;
    endcase
    return z;
  endfunction

endpackage

>>> src/touch_slide_gesture_classifier.sv
// ----------------------------------------------------------------------------
// touch_slide_gesture_classifier
// Picks the primary contact of each touch report and turns presses and
// slides into route, window and line commands, one subtractor step a cycle.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | in_valid_i / in_stall_o| pos_x, pos_y, pressure,
//           |           |                        | tip_switch, last_slot
//  out      | output    | out_valid_o/out_stall_i| command, cell_index
//  cfg      | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A slot that is ignored, releases the touch or ends a report is handled in S_IDLE.
// A motion step runs S_MOTION and S_DECIDE, and S_EMIT when it yields a
// command; a press walks S_ZONE to find its zone, and a routing press goes on
// through S_RSPAN, S_ROFS, S_RMUL, S_DIV and S_EMIT. A single subtractor does
// the bounds, distances and restoring division, one step per cycle.
// Reset clears the control state; the configuration goes to its defaults.
// in_stall_o is high while a request is in work; a finished result sits in
// the output register and holds while out_stall_i is high.
// ----------------------------------------------------------------------------
module touch_slide_gesture_classifier #(
  parameter int unsigned CELL_COUNT       = tsgc_pkg::CELL_COUNT_DEF,
  parameter int unsigned SLOTS_PER_REPORT = tsgc_pkg::SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [tsgc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tsgc_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input slots
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tsgc_pkg::COORD_W-1:0]      pos_x_i,
  input  logic [tsgc_pkg::COORD_W-1:0]      pos_y_i,
  input  logic [tsgc_pkg::COORD_W-1:0]      pressure_i,
  input  logic                              tip_switch_i,
  input  logic                              last_slot_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tsgc_pkg::CMD_W-1:0]        command_o,
  output logic [tsgc_pkg::CELL_W-1:0]       cell_index_o
);
  import tsgc_pkg::*;

  localparam int unsigned QW  = $clog2(CELL_COUNT);
  localparam int unsigned QCW = $clog2(QW + 1);
  localparam int unsigned NW  = COORD_W + $clog2(CELL_COUNT + 1);
  localparam int unsigned SW  = $clog2(SLOTS_PER_REPORT + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ZONE   = 9'b000000010,
    S_RSPAN  = 9'b000000100,
    S_ROFS   = 9'b000001000,
    S_RMUL   = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_MOTION = 9'b001000000,
    S_DECIDE = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_e;

  // Control state
  state_e               state_q, state_d;
  logic                 touch_q, touch_d;
  zone_e                zone_q, zone_d;
  logic                 prim_q, prim_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic                 out_valid_q, out_valid_d;

  // Configuration
  logic [CFG_W-1:0]     bnd_q [BND_N];
  logic [COORD_W-1:0]   thr_q;

  // Work registers
  logic [COORD_W-1:0]   x_q, x_d, y_q, y_d;
  logic [COORD_W-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic [3:0]           zs_q, zs_d;
  logic                 inz_q, inz_d;
  logic [OPW-1:0]       dv_q, dv_d;
  logic [COORD_W-1:0]   r_q, r_d;
  logic [COORD_W-1:0]   rem_q, rem_d;
  logic [QW-1:0]        nsh_q, nsh_d;
  logic [QW-1:0]        quo_q, quo_d;
  logic [QCW-1:0]       dcnt_q, dcnt_d;
  logic [2:0]           mstep_q, mstep_d;
  logic                 xlt_q, xlt_d, ylt_q, ylt_d;
  logic                 right_q, right_d, down_q, down_d;
  logic                 horiz_q, horiz_d, gex_q, gex_d, gey_q, gey_d;
  logic [COORD_W-1:0]   adx_q, adx_d, ady_q, ady_d;
  cmd_e                 res_cmd_q, res_cmd_d;
  logic [CELL_W-1:0]    res_cell_q, res_cell_d;
  cmd_e                 cmd_q, cmd_d;
  logic [CELL_W-1:0]    cell_q, cell_d;

  // Shared unit
  logic [OPW-1:0]       op_a, op_b;
  alu_res_t             alu;

  // Bounds read port
  logic [CFG_IDX_W-1:0] bsel;
  logic [CFG_W-1:0]     bnd_rd;
  logic [COORD_W-1:0]   bmin, bmax;

  logic                 in_acc, present, handle, slot_lt;
  logic [NW-1:0]        prod;
  logic [QW-1:0]        quo_sat;
  logic [OPW-1:0]       div_r;

  tsgc_alu u_alu (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .res_o  (alu)
  );

  assign bnd_rd = bnd_q[bsel];
  assign bmin   = bnd_rd[COORD_W-1:0];
  assign bmax   = bnd_rd[CFG_W-1:COORD_W];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign present    = |{pos_x_i, pos_y_i, pressure_i};
  assign slot_lt    = (slot_q < SW'(SLOTS_PER_REPORT));
  assign handle     = !prim_q && slot_lt && present;

  // Scale the offset into the strip by the cell count
  assign prod  = NW'(r_q) * NW'(CELL_COUNT);
  assign div_r = {rem_q, nsh_q[QW-1]};

  // Pick operands of the shared subtractor
  always_comb begin
    op_a = '0;
    op_b = '0;
    bsel = CFG_ROUTE_X;
    unique case (state_q)
      S_ZONE: begin
        bsel = {zs_q[3:2], zs_q[1]};
        case (zs_q[1:0])
          2'd0:    begin op_a = {1'b0, x_q};  op_b = {1'b0, bmin}; end
          2'd1:    begin op_a = {1'b0, bmax}; op_b = {1'b0, x_q};  end
          2'd2:    begin op_a = {1'b0, y_q};  op_b = {1'b0, bmin}; end
          default: begin op_a = {1'b0, bmax}; op_b = {1'b0, y_q};  end
        endcase
      end
      S_RSPAN: begin
        op_a = {1'b0, bmax};
        op_b = {1'b0, bmin};
      end
      S_ROFS: begin
        op_a = {1'b0, x_q};
        op_b = {1'b0, bmin};
      end
      S_DIV: begin
        op_a = div_r;
        op_b = dv_q;
      end
      S_MOTION: begin
        case (mstep_q)
          3'd0: begin op_a = {1'b0, x_q}; op_b = {1'b0, sx_q}; end
          3'd1: begin
            op_a = {1'b0, xlt_q ? sx_q : x_q};
            op_b = {1'b0, xlt_q ? x_q : sx_q};
          end
          3'd2: begin op_a = {1'b0, y_q}; op_b = {1'b0, sy_q}; end
          3'd3: begin
            op_a = {1'b0, ylt_q ? sy_q : y_q};
            op_b = {1'b0, ylt_q ? y_q : sy_q};
          end
          3'd4: begin op_a = {1'b0, adx_q}; op_b = {1'b0, ady_q}; end
          3'd5: begin op_a = {1'b0, adx_q}; op_b = {1'b0, thr_q}; end
          default: begin op_a = {1'b0, ady_q}; op_b = {1'b0, thr_q}; end
        endcase
      end
      default: ;
    endcase
  end

  // Saturate the next quotient at the last cell
  always_comb begin
    if ({1'b0, quo_d} >= (QW + 1)'(CELL_COUNT)) begin
      quo_sat = QW'(CELL_COUNT - 1);
    end else begin
      quo_sat = quo_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    touch_d    = touch_q;
    zone_d     = zone_q;
    prim_d     = prim_q;
    slot_d     = slot_q;
    x_d        = x_q;
    y_d        = y_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    zs_d       = zs_q;
    inz_d      = inz_q;
    dv_d       = dv_q;
    r_d        = r_q;
    rem_d      = rem_q;
    nsh_d      = nsh_q;
    quo_d      = quo_q;
    dcnt_d     = dcnt_q;
    mstep_d    = mstep_q;
    xlt_d      = xlt_q;
    ylt_d      = ylt_q;
    right_d    = right_q;
    down_d     = down_q;
    horiz_d    = horiz_q;
    gex_d      = gex_q;
    gey_d      = gey_q;
    adx_d      = adx_q;
    ady_d      = ady_q;
    res_cmd_d  = res_cmd_q;
    res_cell_d = res_cell_q;
    cmd_d      = cmd_q;
    cell_d     = cell_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_d = pos_x_i;
          y_d = pos_y_i;
          // Report bookkeeping
          if (last_slot_i) begin
            if (!(prim_q || handle)) begin
              touch_d = 1'b0;
            end
            prim_d = 1'b0;
            slot_d = '0;
          end else begin
            prim_d = prim_q || handle;
            if (slot_lt) begin
              slot_d = slot_q + SW'(1);
            end
          end
          // Primary contact
          if (handle) begin
            if (!tip_switch_i) begin
              touch_d = 1'b0;
            end else if (!touch_q) begin
              touch_d = 1'b1;
              sx_d    = pos_x_i;
              sy_d    = pos_y_i;
              zs_d    = '0;
              state_d = S_ZONE;
            end else begin
              mstep_d = '0;
              state_d = S_MOTION;
            end
          end
        end
      end

      // Walk the rectangles in priority order, one bound per cycle
      S_ZONE: begin
        zs_d = zs_q + 4'd1;
        if (zs_q[1:0] == 2'd0) begin
          inz_d = !alu.borrow;
        end else begin
          inz_d = inz_q && !alu.borrow;
        end
        if (zs_q[1:0] == 2'd3) begin
          if (inz_q && !alu.borrow) begin
            zone_d  = zone_of_rect(zs_q[3:2]);
            state_d = (zs_q[3:2] == 2'd0) ? S_RSPAN : S_IDLE;
          end else if (zs_q[3:2] == 2'd2) begin
            zone_d  = ZONE_NONE;
            state_d = S_IDLE;
          end
        end
      end

      // Strip width; drop the route when the upper bound is not above the lower
      S_RSPAN: begin
        dv_d = alu.diff + OPW'(1);
        if (alu.borrow || alu.zero) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_ROFS;
        end
      end

      S_ROFS: begin
        r_d     = alu.diff[COORD_W-1:0];
        state_d = S_RMUL;
      end

      S_RMUL: begin
        rem_d   = COORD_W'(prod >> QW);
        nsh_d   = QW'(prod);
        quo_d   = '0;
        dcnt_d  = QCW'(QW);
        state_d = S_DIV;
      end

      // Restoring division, one quotient bit per cycle
      S_DIV: begin
        rem_d  = alu.borrow ? div_r[COORD_W-1:0] : alu.diff[COORD_W-1:0];
        nsh_d  = nsh_q << 1;
        quo_d  = (quo_q << 1) | QW'(!alu.borrow);
        dcnt_d = dcnt_q - QCW'(1);
        if (dcnt_q == QCW'(1)) begin
          res_cmd_d  = CMD_ROUTE;
          res_cell_d = CELL_W'(quo_sat);
          state_d    = S_EMIT;
        end
      end

      // Distances and threshold compares
      S_MOTION: begin
        mstep_d = mstep_q + 3'd1;
        case (mstep_q)
          3'd0: begin
            xlt_d   = alu.borrow;
            right_d = !alu.borrow && !alu.zero;
          end
          3'd1: adx_d = alu.diff[COORD_W-1:0];
          3'd2: begin
            ylt_d  = alu.borrow;
            down_d = !alu.borrow && !alu.zero;
          end
          3'd3: ady_d = alu.diff[COORD_W-1:0];
          3'd4: horiz_d = !alu.borrow;
          3'd5: gex_d = !alu.borrow;
          default: begin
            gey_d   = !alu.borrow;
            state_d = S_DECIDE;
          end
        endcase
      end

      // Rebase the start point and choose the command
      S_DECIDE: begin
        state_d = S_IDLE;
        if (gex_q || gey_q) begin
          sx_d = x_q;
          sy_d = y_q;
          res_cell_d = '0;
          if (horiz_q) begin
            res_cmd_d = right_q ? CMD_WIN_RIGHT : CMD_WIN_LEFT;
          end else begin
            res_cmd_d = down_q ? CMD_LINE_DOWN : CMD_LINE_UP;
          end
          if (zone_q == ZONE_RIGHT) begin
            state_d = S_EMIT;
          end else if ((zone_q == ZONE_LEFT || zone_q == ZONE_ROUTING) && horiz_q) begin
            state_d = S_EMIT;
          end
        end
      end

      // Hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          cmd_d       = res_cmd_q;
          cell_d      = res_cell_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      touch_q     <= 1'b0;
      zone_q      <= ZONE_NONE;
      prim_q      <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      thr_q       <= THR_RESET;
      for (int i = 0; i < BND_N; i++) begin
        bnd_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      touch_q     <= touch_d;
      zone_q      <= zone_d;
      prim_q      <= prim_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ROUTE_X, CFG_ROUTE_Y, CFG_LEFT_X,
          CFG_LEFT_Y, CFG_RIGHT_X, CFG_RIGHT_Y: bnd_q[cfg_idx_i] <= cfg_wdata_i;
          CFG_THRESH: thr_q <= cfg_wdata_i[COORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    zs_q       <= zs_d;
    inz_q      <= inz_d;
    dv_q       <= dv_d;
    r_q        <= r_d;
    rem_q      <= rem_d;
    nsh_q      <= nsh_d;
    quo_q      <= quo_d;
    dcnt_q     <= dcnt_d;
    mstep_q    <= mstep_d;
    xlt_q      <= xlt_d;
    ylt_q      <= ylt_d;
    right_q    <= right_d;
    down_q     <= down_d;
    horiz_q    <= horiz_d;
    gex_q      <= gex_d;
    gey_q      <= gey_d;
    adx_q      <= adx_d;
    ady_q      <= ady_d;
    res_cmd_q  <= res_cmd_d;
    res_cell_q <= res_cell_d;
    cmd_q      <= cmd_d;
    cell_q     <= cell_d;
  end

  assign out_valid_o  = out_valid_q;
  assign command_o    = cmd_q;
  assign cell_index_o = cell_q;

  // Only route commands carry a cell
  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_o != CMD_ROUTE) |-> (cell_index_o == '0))
    else $error("cell index set on a non-route command");

  // A route result comes only from a press in the routing strip
  a_route_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_cmd_q == CMD_ROUTE) |-> (zone_q == ZONE_ROUTING && touch_q))
    else $error("route command outside the routing strip");

  // The slot count never passes the report size
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SW'(SLOTS_PER_REPORT))
    else $error("slot count overflow");

  // A slide result needs an active touch
  a_slide_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> touch_q)
    else $error("slide decision without an active touch");

endmodule

>>> src/tsgc_alu.sv
// ----------------------------------------------------------------------------
// tsgc_alu
// Shared subtractor: difference of two unsigned operands with borrow and
// zero flags; used for bound compares, distances and division steps.
// ----------------------------------------------------------------------------
module tsgc_alu (
  input  logic [tsgc_pkg::OPW-1:0] op_a_i,
  input  logic [tsgc_pkg::OPW-1:0] op_b_i,
  output tsgc_pkg::alu_res_t       res_o
);
  import tsgc_pkg::*;

  logic [OPW:0] full;

  // Subtract with one extra bit to catch the borrow
  assign full = {1'b0, op_a_i} - {1'b0, op_b_i};

  assign res_o.diff   = full[OPW-1:0];
  assign res_o.borrow = full[OPW];
  assign res_o.zero   = (full[OPW-1:0] == '0);

endmodule
